// ===== hdl/stb_pkg.sv =====
// Shared constants, command codes and controller/datapath structs for the
// scaled texture rectangle blitter. No dependencies.
`default_nettype none

package stb_pkg;

  // Fixed-point accumulator format and field widths
  localparam int FRAC_BITS   = 16;
  localparam int ACC_W       = 20;
  localparam int ADDR_W      = 17;
  localparam int COLOUR_W    = 16;
  localparam int IDX_W       = 11;
  localparam int STORE_DEPTH = 2048;
  localparam int OP_W        = 2;
  localparam int COORD_W     = 12;
  localparam int SIZE_W      = 11;
  localparam int TSEL_W      = 3;
  localparam int OFS_W       = 4;
  // Signed width that holds an edge plus a size without overflow
  localparam int CLIP_W      = 14;

  // Parameter defaults
  localparam int TEX_DIM_DEF   = 16;
  localparam int FB_WIDTH_DEF  = 320;
  localparam int FB_HEIGHT_DEF = 240;

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_STEP  = 2'd2;

  typedef struct packed {
    logic load;
    logic start;
    logic setup_mul;
    logic acc_load;
    logic step;
  } stb_cmd_t;

  typedef struct packed {
    logic rect_ok;
    logic div_done;
    logic busy;
    logic slot_free;
  } stb_status_t;

endpackage

`default_nettype wire

// ===== hdl/stb_req_if.sv =====
// Request channel: valid/ready handshake with the operation payload.
// Depends on stb_pkg.
`default_nettype none

interface stb_req_if
  import stb_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic [IDX_W-1:0]         texel_index;
  logic [COLOUR_W-1:0]      texel_value;
  logic [TSEL_W-1:0]        texture_select;
  logic signed [COORD_W-1:0] rect_x;
  logic signed [COORD_W-1:0] rect_y;
  logic [SIZE_W-1:0]        rect_width;
  logic [SIZE_W-1:0]        rect_height;
  logic [OFS_W-1:0]         u_origin;
  logic [OFS_W-1:0]         v_origin;

  modport source (
    output valid, op, texel_index, texel_value, texture_select,
           rect_x, rect_y, rect_width, rect_height, u_origin, v_origin,
    input  ready
  );

  modport sink (
    input  valid, op, texel_index, texel_value, texture_select,
           rect_x, rect_y, rect_width, rect_height, u_origin, v_origin,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/stb_res_if.sv =====
// Result channel: valid/ready handshake carrying one framebuffer write.
// Depends on stb_pkg.
`default_nettype none

interface stb_res_if
  import stb_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   fb_address;
  logic [COLOUR_W-1:0] pixel_colour;
  logic                last;

  modport source (
    output valid, fb_address, pixel_colour, last,
    input  ready
  );

  modport sink (
    input  valid, fb_address, pixel_colour, last,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/stb_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module stb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/stb_div.sv =====
// Restoring divider, one quotient bit per cycle, constant dividend.
// No dependencies.
`default_nettype none

module stb_div #(
  parameter int          DVD_W    = 21,
  parameter int unsigned DIVIDEND = 1048576,
  parameter int          DVS_W    = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam logic [DVD_W-1:0] DVD   = DVD_W'(DIVIDEND);
  localparam int               CNT_W = $clog2(DVD_W + 1);

  logic             run;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             fits;

  // Shift in the next dividend bit and try a subtract
  assign trial    = {rem, quotient[DVD_W-1]};
  assign diff     = trial - {1'b0, dvs};
  assign fits     = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && cnt == CNT_W'(1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt      <= CNT_W'(DVD_W);
      quotient <= DVD;
      rem      <= '0;
      dvs      <= divisor;
    end else if (run) begin
      cnt      <= cnt - CNT_W'(1);
      quotient <= {quotient[DVD_W-2:0], fits};
      rem      <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/stb_ctl.sv =====
// Controller: sequences rectangle setup and issues datapath commands.
// Depends on stb_pkg.
`default_nettype none

module stb_ctl
  import stb_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  logic [OP_W-1:0] req_op,
  input  stb_status_t     status,
  output logic            req_ready,
  output stb_cmd_t        cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_LOAD = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign req_ready = (state == S_IDLE) && status.slot_free;
  assign accept    = req_valid && req_ready;

  always_comb begin
    cmd.load      = accept && (req_op == OP_LOAD);
    cmd.start     = accept && (req_op == OP_START);
    cmd.step      = accept && (req_op == OP_STEP) && status.busy;
    cmd.setup_mul = (state == S_MUL);
    cmd.acc_load  = (state == S_LOAD);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.start && status.rect_ok) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (status.div_done) begin
          state_next = S_MUL;
        end
      end
      S_MUL:   state_next = S_LOAD;
      S_LOAD:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/stb_dp.sv =====
// Datapath: clipping, step dividers, accumulators, texture store and
// output registers. Depends on stb_pkg, stb_ram, stb_div, stb_res_if.
`default_nettype none

module stb_dp
  import stb_pkg::*;
#(
  parameter int TEX_DIM   = TEX_DIM_DEF,
  parameter int FB_WIDTH  = FB_WIDTH_DEF,
  parameter int FB_HEIGHT = FB_HEIGHT_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  stb_cmd_t                  cmd,
  input  logic [IDX_W-1:0]          texel_index,
  input  logic [COLOUR_W-1:0]       texel_value,
  input  logic [TSEL_W-1:0]         texture_select,
  input  logic signed [COORD_W-1:0] rect_x,
  input  logic signed [COORD_W-1:0] rect_y,
  input  logic [SIZE_W-1:0]         rect_width,
  input  logic [SIZE_W-1:0]         rect_height,
  input  logic [OFS_W-1:0]          u_origin,
  input  logic [OFS_W-1:0]          v_origin,
  output stb_status_t               status,
  stb_res_if.source                 res
);

  localparam int TEX_BITS = $clog2(TEX_DIM);
  localparam int DVD_W    = TEX_BITS + FRAC_BITS + 1;
  localparam int COL_W    = $clog2(FB_WIDTH + 1);
  localparam int ROW_W    = $clog2(FB_HEIGHT + 1);
  localparam logic signed [CLIP_W-1:0] FBW_S = CLIP_W'(FB_WIDTH);
  localparam logic signed [CLIP_W-1:0] FBH_S = CLIP_W'(FB_HEIGHT);
  localparam logic [COL_W-1:0]  FBW_C   = COL_W'(FB_WIDTH);
  localparam logic [ADDR_W-1:0] FBW_A   = ADDR_W'(FB_WIDTH);
  localparam logic [31:0]       TEX_MSK = 32'(TEX_DIM - 1);

  // Clipping (combinational on the start request)
  logic signed [CLIP_W-1:0] x_s, y_s, w_s, h_s;
  logic signed [CLIP_W-1:0] x0_s, y0_s, x1_s, y1_s, x1c, y1c;
  logic signed [CLIP_W-1:0] dx_s, dy_s;
  logic                     rect_ok;

  assign x_s  = CLIP_W'(rect_x);
  assign y_s  = CLIP_W'(rect_y);
  assign w_s  = CLIP_W'(rect_width);
  assign h_s  = CLIP_W'(rect_height);
  assign x0_s = x_s[CLIP_W-1] ? '0 : x_s;
  assign y0_s = y_s[CLIP_W-1] ? '0 : y_s;
  assign x1_s = x_s + w_s;
  assign y1_s = y_s + h_s;
  assign x1c  = (x1_s > FBW_S) ? FBW_S : x1_s;
  assign y1c  = (y1_s > FBH_S) ? FBH_S : y1_s;
  assign dx_s = x0_s - x_s;
  assign dy_s = y0_s - y_s;
  assign rect_ok = (rect_width != '0) && (rect_height != '0) &&
                   (x0_s < x1c) && (y0_s < y1c);

  // Rectangle state
  logic                busy;
  logic [TSEL_W-1:0]   active_texture;
  logic [COL_W-1:0]    cur_col, col_begin, col_end;
  logic [ROW_W-1:0]    cur_row, row_end;
  logic [COORD_W-1:0]  dx, dy;
  logic [OFS_W-1:0]    u_off, v_off;
  logic [ACC_W-1:0]    u_step_reg, v_step_reg, u_row_start, u_accum, v_accum;
  logic [ACC_W-1:0]    prod_u, prod_v;
  logic [ADDR_W-1:0]   row_base;

  // Step dividers
  logic             done_u, done_v;
  logic [DVD_W-1:0] quo_u, quo_v;
  logic             div_start;

  assign div_start = cmd.start && rect_ok;

  stb_div #(
    .DVD_W    (DVD_W),
    .DIVIDEND (TEX_DIM << FRAC_BITS),
    .DVS_W    (SIZE_W)
  ) u_div_u (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (rect_width),
    .done     (done_u),
    .quotient (quo_u)
  );

  stb_div #(
    .DVD_W    (DVD_W),
    .DIVIDEND (TEX_DIM << FRAC_BITS),
    .DVS_W    (SIZE_W)
  ) u_div_v (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (rect_height),
    .done     (done_v),
    .quotient (quo_v)
  );

  logic [ACC_W-1:0]         step_u, step_v;
  logic [COORD_W+ACC_W-1:0] mul_u, mul_v;
  logic [ROW_W+COL_W-1:0]   mul_row;

  assign step_u  = ACC_W'(quo_u);
  assign step_v  = ACC_W'(quo_v);
  assign mul_u   = dx * step_u;
  assign mul_v   = dy * step_v;
  assign mul_row = cur_row * FBW_C;

  // Per-pixel arithmetic
  logic [COL_W-1:0]  col_inc;
  logic [ROW_W-1:0]  row_inc;
  logic              row_wrap, is_last;
  logic [31:0]       tx, ty, idx_w;
  logic [ADDR_W-1:0] pix_addr;

  assign col_inc  = cur_col + COL_W'(1);
  assign row_inc  = cur_row + ROW_W'(1);
  assign row_wrap = col_inc >= col_end;
  assign is_last  = row_wrap && (row_inc >= row_end);
  assign tx       = 32'(u_accum[ACC_W-1:FRAC_BITS]) & TEX_MSK;
  assign ty       = 32'(v_accum[ACC_W-1:FRAC_BITS]) & TEX_MSK;
  assign idx_w    = (32'(active_texture) << (2 * TEX_BITS)) + (ty << TEX_BITS) + tx;
  assign pix_addr = row_base + ADDR_W'(cur_col);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (cmd.start) begin
      busy <= 1'b0;
    end else if (cmd.acc_load) begin
      busy <= 1'b1;
    end else if (cmd.step && is_last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      active_texture <= texture_select;
      col_begin      <= x0_s[COL_W-1:0];
      cur_col        <= x0_s[COL_W-1:0];
      col_end        <= x1c[COL_W-1:0];
      cur_row        <= y0_s[ROW_W-1:0];
      row_end        <= y1c[ROW_W-1:0];
      dx             <= dx_s[COORD_W-1:0];
      dy             <= dy_s[COORD_W-1:0];
      u_off          <= u_origin;
      v_off          <= v_origin;
    end else if (cmd.step) begin
      if (row_wrap) begin
        cur_col  <= col_begin;
        cur_row  <= row_inc;
        row_base <= row_base + FBW_A;
        u_accum  <= u_row_start;
        v_accum  <= v_accum + v_step_reg;
      end else begin
        cur_col  <= col_inc;
        u_accum  <= u_accum + u_step_reg;
      end
    end
    if (cmd.setup_mul) begin
      u_step_reg <= step_u;
      v_step_reg <= step_v;
      prod_u     <= mul_u[ACC_W-1:0];
      prod_v     <= mul_v[ACC_W-1:0];
      row_base   <= ADDR_W'(mul_row);
    end
    if (cmd.acc_load) begin
      u_row_start <= ACC_W'({u_off, {FRAC_BITS{1'b0}}}) + prod_u;
      u_accum     <= ACC_W'({u_off, {FRAC_BITS{1'b0}}}) + prod_u;
      v_accum     <= ACC_W'({v_off, {FRAC_BITS{1'b0}}}) + prod_v;
    end
  end

  // Texture store
  logic [COLOUR_W-1:0] rdata;

  stb_ram #(
    .WIDTH (COLOUR_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.load),
    .waddr (texel_index),
    .wdata (texel_value),
    .re    (cmd.step),
    .raddr (idx_w[IDX_W-1:0]),
    .rdata (rdata)
  );

  // Pending stage (waits on read data) and output register
  logic                pend_valid, pend_last, move;
  logic [ADDR_W-1:0]   pend_addr;
  logic                out_valid, out_last;
  logic [ADDR_W-1:0]   out_addr;
  logic [COLOUR_W-1:0] out_colour;

  assign move = pend_valid && (!out_valid || res.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.step) begin
        pend_valid <= 1'b1;
      end else if (move) begin
        pend_valid <= 1'b0;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      pend_addr <= pix_addr;
      pend_last <= is_last;
    end
    if (move) begin
      out_addr   <= pend_addr;
      out_colour <= rdata;
      out_last   <= pend_last;
    end
  end

  assign res.valid        = out_valid;
  assign res.fb_address   = out_addr;
  assign res.pixel_colour = out_colour;
  assign res.last         = out_last;

  assign status.rect_ok   = rect_ok;
  assign status.div_done  = done_u && done_v;
  assign status.busy      = busy;
  assign status.slot_free = !pend_valid || move;

endmodule

`default_nettype wire

// ===== hdl/scaled_texture_rect_blitter_top.sv =====
// Top level of the scaled texture rectangle blitter: controller, datapath
// and checks. Depends on stb_pkg, stb_req_if, stb_res_if, stb_ctl, stb_dp.
//
// Usage. One request channel (req) carries every operation; one result
// channel (res) carries framebuffer writes. Both use valid/ready and a
// transaction completes at a rising edge with valid and ready high.
//   Load texel: writes texel_value at texel_index, one per cycle while ready.
//   Start rectangle: clips to the framebuffer and computes the 4.16 steps
//     with two restoring dividers, one quotient bit a cycle. req.ready drops
//     while the dividers produce log2(TEX_DIM)+17 quotient bits, then for the
//     done strobe, the multiply state and the accumulator load state.
//     Empty or fully clipped rectangles keep ready up and emit nothing.
//   Step: emits the next pixel of the rectangle in row order; last marks
//     the final pixel. A step while no rectangle is active emits nothing.
// A step transaction registers the texture read and the pending pixel;
// the output register takes them when it is empty or res is ready.
// Throughput: one step per cycle while res keeps up; a pending pixel and
// the output register absorb a stall, after which req.ready drops until
// res takes a transaction.
// Reset clears the active rectangle and both output stages; the texture
// store is not cleared and texels must be loaded before they are sampled.
`default_nettype none

module scaled_texture_rect_blitter_top
  import stb_pkg::*;
#(
  parameter int TEX_DIM   = TEX_DIM_DEF,
  parameter int FB_WIDTH  = FB_WIDTH_DEF,
  parameter int FB_HEIGHT = FB_HEIGHT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  stb_req_if.sink   req,
  stb_res_if.source res
);

  stb_cmd_t    cmd;
  stb_status_t status;

  // Controller: owns req.ready and sequences the setup steps
  stb_ctl u_ctl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_op    (req.op),
    .status    (status),
    .req_ready (req.ready),
    .cmd       (cmd)
  );

  // Datapath: all arithmetic, the texture store and the result registers
  stb_dp #(
    .TEX_DIM   (TEX_DIM),
    .FB_WIDTH  (FB_WIDTH),
    .FB_HEIGHT (FB_HEIGHT)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .texel_index    (req.texel_index),
    .texel_value    (req.texel_value),
    .texture_select (req.texture_select),
    .rect_x         (req.rect_x),
    .rect_y         (req.rect_y),
    .rect_width     (req.rect_width),
    .rect_height    (req.rect_height),
    .u_origin       (req.u_origin),
    .v_origin       (req.v_origin),
    .status         (status),
    .res            (res)
  );

  // Requests are only taken outside the setup sequence
  a_ready_outside_setup: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !cmd.setup_mul && !cmd.acc_load)
    else $error("request accepted during rectangle setup");

  // The multiply cycle is always followed by the accumulator load
  a_mul_then_load: assert property (@(posedge clk) disable iff (rst)
    cmd.setup_mul |=> cmd.acc_load)
    else $error("accumulator load did not follow multiply");

  // A loaded rectangle is active
  a_load_sets_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.acc_load |=> status.busy)
    else $error("rectangle not active after setup");

  // A start abandons any rectangle in progress
  a_start_clears_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> !status.busy)
    else $error("rectangle still active after start");

endmodule

`default_nettype wire
